// File: rtl/core/psm_pkg.sv
// Shared types and constants for the packet sequence monitor.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package psm_pkg;

  localparam logic [31:0] HDR_MAGIC     = 32'h5150_5246;
  localparam logic [11:0] HDR_MIN_BYTES = 12'd16;

  localparam int unsigned LEN_W   = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTES_W = 48;

  // Input beat: 76 bits of fields, padded to 80.
  localparam int unsigned S_TDATA_W = 80;
  // Result beat: five counters, 176 bits.
  localparam int unsigned M_TDATA_W = 176;

  typedef struct packed {
    logic [WORD_W-1:0] sequence_number;
    logic [WORD_W-1:0] magic_word;
    logic [LEN_W-1:0]  packet_length;
  } hdr_t;

  typedef struct packed {
    logic [WORD_W-1:0]  reorder_total;
    logic [WORD_W-1:0]  duplicate_total;
    logic [WORD_W-1:0]  lost_total;
    logic [BYTES_W-1:0] byte_total;
    logic [WORD_W-1:0]  packet_total;
  } totals_t;

endpackage

// File: rtl/core/packet_sequence_monitor.sv
// Receive-side sequence checker: counts packets, bytes, lost, duplicate and reordered beats.
// Depends on psm_pkg.
`timescale 1ns / 1ps

//  Channel  | Direction | tdata (low bit first)                          | tuser
//  s_axis   | in        | packet_length, magic_word, sequence_number, pad | -
//  m_axis   | out       | packet_total, byte_total, lost_total,           | accepted
//           |           | duplicate_total, reorder_total                  |
//
// One beat is accepted per cycle while m_axis is not stalled; each beat passes through
// the input register and then the counter/result register before its result appears.
// The counters themselves form the result register and change only when a result moves.
// A stalled m_axis holds its beat; s_axis keeps taking one more beat into the input register.
// rst clears all counters, the highest sequence number and both valid flags.

module packet_sequence_monitor
  import psm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // packet_length[11:0], magic_word[43:12], sequence_number[75:44], zeros[79:76]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // packet_total[31:0], byte_total[79:32], lost_total[111:80],
  // duplicate_total[143:112], reorder_total[175:144]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // accepted[0]
  output logic [0:0]           m_axis_tuser
);

  hdr_t    hdr;
  logic    hdr_valid;
  logic    advance;

  logic    seen_any, seen_any_next;
  logic [WORD_W-1:0] highest_sequence, highest_sequence_next;
  totals_t totals, totals_next;
  logic    accepted, accepted_next;

  logic                ok;
  logic [WORD_W-1:0]   gap;
  logic [WORD_W:0]     lost_sum;
  logic [BYTES_W:0]    byte_sum;

  assign advance       = hdr_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !hdr_valid || advance;

  always_comb begin
    ok = (hdr.packet_length >= HDR_MIN_BYTES) && (hdr.magic_word == HDR_MAGIC);
    // seq - highest - 1, meaningful only when seq is ahead.
    gap      = hdr.sequence_number + ~highest_sequence;
    lost_sum = {1'b0, totals.lost_total} + {1'b0, gap};
    byte_sum = {1'b0, totals.byte_total} + {{(BYTES_W + 1 - LEN_W){1'b0}}, hdr.packet_length};

    seen_any_next         = seen_any;
    highest_sequence_next = highest_sequence;
    totals_next           = totals;
    accepted_next         = ok;

    if (ok) begin
      if (totals.packet_total != '1) begin
        totals_next.packet_total = totals.packet_total + 1'b1;
      end
      totals_next.byte_total = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
      if (!seen_any) begin
        seen_any_next         = 1'b1;
        highest_sequence_next = hdr.sequence_number;
      end else if (hdr.sequence_number > highest_sequence) begin
        totals_next.lost_total = lost_sum[WORD_W] ? '1 : lost_sum[WORD_W-1:0];
        highest_sequence_next  = hdr.sequence_number;
      end else if (hdr.sequence_number == highest_sequence) begin
        if (totals.duplicate_total != '1) begin
          totals_next.duplicate_total = totals.duplicate_total + 1'b1;
        end
      end else begin
        if (totals.reorder_total != '1) begin
          totals_next.reorder_total = totals.reorder_total + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      hdr_valid <= 1'b1;
    end else if (advance) begin
      hdr_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      hdr <= s_axis_tdata[$bits(hdr_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid    <= 1'b0;
      seen_any         <= 1'b0;
      highest_sequence <= '0;
      totals           <= '0;
      accepted         <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid    <= 1'b1;
      seen_any         <= seen_any_next;
      highest_sequence <= highest_sequence_next;
      totals           <= totals_next;
      accepted         <= accepted_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid    <= 1'b0;
    end
  end

  assign m_axis_tdata = totals;
  assign m_axis_tuser = accepted;

endmodule

// File: rtl/core/psm_checker.sv
// Port-level checker for packet_sequence_monitor, attached by bind.
// Depends on psm_pkg.
`timescale 1ns / 1ps

module psm_checker
  import psm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]           m_axis_tuser
);

  // Out of reset nothing is pending and the input side is open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("monitor not idle after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result beat changed while stalled");

  // The packet count never goes backward outside reset.
  a_packets_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (m_axis_tdata[31:0] >= $past(m_axis_tdata[31:0])))
    else $error("packet total decreased");

  // An accepted packet has been counted, with at least a minimum header of bytes.
  a_accepted_counted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((m_axis_tdata[31:0] != '0) && (m_axis_tdata[79:32] >= 48'd16)))
    else $error("accepted beat without matching counts");

endmodule

bind packet_sequence_monitor psm_checker u_psm_checker (.*);
